>>> rtl/dtq_pkg.sv
// package: shared constants, codes and types of the deadline timer queue
package dtq_pkg;

  // table geometry
  localparam int unsigned DEPTH    = 16;
  localparam int unsigned IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
  localparam int unsigned MAX_POPS = 16;
  localparam int unsigned POP_W    = $clog2(MAX_POPS + 1);

  // field widths
  localparam int unsigned OP_W   = 3;
  localparam int unsigned TIME_W = 64;
  localparam int unsigned TAG_W  = 16;
  localparam int unsigned ST_W   = 2;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 3'd0,
    OP_REG   = 3'd1,
    OP_START = 3'd2,
    OP_STOP  = 3'd3,
    OP_READ  = 3'd4
  } op_e;

  // status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOT_RUN = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  // result kinds
  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_EXPIRY = 1'b1
  } kind_e;

  // control sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_REPLY,
    S_INS_RD,
    S_INS_CMP,
    S_TK_RD,
    S_TK_CHK
  } state_e;

  // one table entry
  typedef struct packed {
    logic [TIME_W-1:0] deadline;
    logic [TAG_W-1:0]  owner;
  } entry_t;

  // table access request from the sequencer
  typedef struct packed {
    logic [IDX_W-1:0] head;
    logic             re;
    logic [CNT_W-1:0] rd_off;
    logic             we;
    logic [CNT_W-1:0] wr_off;
    entry_t           wdata;
  } tbl_req_t;

endpackage

>>> rtl/dtq_ifs.sv
// interfaces: command channel and result channel with valid/ready
interface dtq_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [dtq_pkg::OP_W-1:0]     op;
  logic [dtq_pkg::TIME_W-1:0]   delay;
  logic [dtq_pkg::TAG_W-1:0]    owner_tag;

  modport source (output valid, output op, output delay, output owner_tag, input ready);
  modport sink   (input valid, input op, input delay, input owner_tag, output ready);
endinterface

interface dtq_res_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [dtq_pkg::ST_W-1:0]     status;
  logic [dtq_pkg::TAG_W-1:0]    expired_owner;
  logic [dtq_pkg::TIME_W-1:0]   now_time;
  logic                         last;

  modport source (output valid, output kind, output status, output expired_owner,
                  output now_time, output last, input ready);
  modport sink   (input valid, input kind, input status, input expired_owner,
                  input now_time, input last, output ready);
endinterface

>>> rtl/deadline_timer_queue.sv
// top level: deadline-sorted one-shot timer queue with a 64-bit time count
// The block takes one command at a time. Read time, start and stop give their
// status reply through the reply state. A register command, when running and
// not full, walks the table from its tail in a single memory, moving each
// entry at or after the new deadline up one slot and then writing the new
// entry into the hole. A tick reads entries from the head one at a time, pops
// up to 16 due entries and waits while the result side holds ready low. The
// table memory has a registered read. It holds DEPTH entries and needs no
// clearing after reset.
module deadline_timer_queue (
  input  logic      clk_i,
  input  logic      rst_ni,
  dtq_cmd_if.sink   in_i,
  dtq_res_if.source out_o
);

  typedef struct packed {
    logic                       kind;
    logic [dtq_pkg::ST_W-1:0]   status;
    logic [dtq_pkg::TAG_W-1:0]  owner;
    logic [dtq_pkg::TIME_W-1:0] now;
    logic                       last;
  } res_t;

  dtq_pkg::state_e            state_q, state_d;
  logic [dtq_pkg::TIME_W-1:0] time_q, time_d;
  logic                       running_q, running_d;
  logic [dtq_pkg::CNT_W-1:0]  count_q, count_d;
  logic [dtq_pkg::IDX_W-1:0]  head_q, head_d;
  logic [dtq_pkg::CNT_W-1:0]  k_q, k_d;
  logic [dtq_pkg::POP_W-1:0]  n_q, n_d;
  dtq_pkg::entry_t            newe_q, newe_d;
  logic [dtq_pkg::TAG_W-1:0]  pend_q, pend_d;
  logic                       have_pend_q, have_pend_d;
  logic [dtq_pkg::ST_W-1:0]   rep_st_q, rep_st_d;
  logic                       ov_q, ov_d;
  res_t                       res_q, res_d;

  dtq_pkg::tbl_req_t          req;
  dtq_pkg::entry_t            rdata;
  logic                       out_free;
  logic [dtq_pkg::TIME_W:0]   dl_sum;

  dtq_table u_table (
    .clk_i   (clk_i),
    .req_i   (req),
    .rdata_o (rdata)
  );

  assign out_free = !ov_q || out_o.ready;
  assign dl_sum   = {1'b0, time_q} + {1'b0, in_i.delay};

  // sequencer: next state, table requests and result loading
  always_comb begin
    state_d     = state_q;
    time_d      = time_q;
    running_d   = running_q;
    count_d     = count_q;
    head_d      = head_q;
    k_d         = k_q;
    n_d         = n_q;
    newe_d      = newe_q;
    pend_d      = pend_q;
    have_pend_d = have_pend_q;
    rep_st_d    = rep_st_q;
    ov_d        = ov_q && !out_o.ready;
    res_d       = res_q;
    in_i.ready  = 1'b0;
    req         = '0;
    req.head    = head_q;

    case (state_q)
      dtq_pkg::S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          case (in_i.op)
            dtq_pkg::OP_TICK: begin
              if (running_q) begin
                if (time_q != '1) begin
                  time_d = time_q + 1'b1;
                end
                n_d         = '0;
                have_pend_d = 1'b0;
                state_d     = dtq_pkg::S_TK_RD;
              end
            end
            dtq_pkg::OP_REG: begin
              state_d = dtq_pkg::S_REPLY;
              if (!running_q) begin
                rep_st_d = dtq_pkg::ST_NOT_RUN;
              end else if (count_q == dtq_pkg::CNT_W'(dtq_pkg::DEPTH)) begin
                rep_st_d = dtq_pkg::ST_FULL;
              end else begin
                newe_d.deadline = dl_sum[dtq_pkg::TIME_W] ? '1 : dl_sum[dtq_pkg::TIME_W-1:0];
                newe_d.owner    = in_i.owner_tag;
                k_d             = count_q;
                state_d         = dtq_pkg::S_INS_RD;
              end
            end
            dtq_pkg::OP_START: begin
              running_d = 1'b1;
              rep_st_d  = dtq_pkg::ST_OK;
              state_d   = dtq_pkg::S_REPLY;
            end
            dtq_pkg::OP_STOP: begin
              if (!running_q) begin
                rep_st_d = dtq_pkg::ST_NOT_RUN;
              end else begin
                running_d = 1'b0;
                count_d   = '0;
                rep_st_d  = dtq_pkg::ST_OK;
              end
              state_d = dtq_pkg::S_REPLY;
            end
            dtq_pkg::OP_READ: begin
              rep_st_d = dtq_pkg::ST_OK;
              state_d  = dtq_pkg::S_REPLY;
            end
            default: begin
            end
          endcase
        end
      end

      // status reply waits for a free output register
      dtq_pkg::S_REPLY: begin
        if (out_free) begin
          ov_d         = 1'b1;
          res_d.kind   = dtq_pkg::KIND_STATUS;
          res_d.status = rep_st_q;
          res_d.owner  = '0;
          res_d.now    = time_q;
          res_d.last   = 1'b1;
          state_d      = dtq_pkg::S_IDLE;
        end
      end

      // insertion: read the entry below the hole, or write the new entry at the head
      dtq_pkg::S_INS_RD: begin
        if (k_q == '0) begin
          req.we     = 1'b1;
          req.wr_off = '0;
          req.wdata  = newe_q;
          count_d    = count_q + 1'b1;
          rep_st_d   = dtq_pkg::ST_OK;
          state_d    = dtq_pkg::S_REPLY;
        end else begin
          req.re     = 1'b1;
          req.rd_off = k_q - 1'b1;
          state_d    = dtq_pkg::S_INS_CMP;
        end
      end

      // insertion: shift a later-or-equal entry up, or drop the new one in
      dtq_pkg::S_INS_CMP: begin
        req.we     = 1'b1;
        req.wr_off = k_q;
        if (rdata.deadline >= newe_q.deadline) begin
          req.wdata = rdata;
          k_d       = k_q - 1'b1;
          state_d   = dtq_pkg::S_INS_RD;
        end else begin
          req.wdata = newe_q;
          count_d   = count_q + 1'b1;
          rep_st_d  = dtq_pkg::ST_OK;
          state_d   = dtq_pkg::S_REPLY;
        end
      end

      // tick: fetch the head entry or finish
      dtq_pkg::S_TK_RD: begin
        if (count_q != '0 && n_q != dtq_pkg::POP_W'(dtq_pkg::MAX_POPS)) begin
          req.re     = 1'b1;
          req.rd_off = '0;
          state_d    = dtq_pkg::S_TK_CHK;
        end else if (!have_pend_q) begin
          state_d = dtq_pkg::S_IDLE;
        end else if (out_free) begin
          ov_d         = 1'b1;
          res_d.kind   = dtq_pkg::KIND_EXPIRY;
          res_d.status = dtq_pkg::ST_OK;
          res_d.owner  = pend_q;
          res_d.now    = time_q;
          res_d.last   = 1'b1;
          state_d      = dtq_pkg::S_IDLE;
        end
      end

      // tick: pop a due head entry or finish, holding each popped entry back to know the last flag
      dtq_pkg::S_TK_CHK: begin
        if (rdata.deadline <= time_q) begin
          if (!have_pend_q || out_free) begin
            if (have_pend_q) begin
              ov_d         = 1'b1;
              res_d.kind   = dtq_pkg::KIND_EXPIRY;
              res_d.status = dtq_pkg::ST_OK;
              res_d.owner  = pend_q;
              res_d.now    = time_q;
              res_d.last   = 1'b0;
            end
            pend_d      = rdata.owner;
            have_pend_d = 1'b1;
            head_d      = (head_q == dtq_pkg::IDX_W'(dtq_pkg::DEPTH - 1)) ? '0 : head_q + 1'b1;
            count_d     = count_q - 1'b1;
            n_d         = n_q + 1'b1;
            state_d     = dtq_pkg::S_TK_RD;
          end
        end else if (!have_pend_q) begin
          state_d = dtq_pkg::S_IDLE;
        end else if (out_free) begin
          ov_d         = 1'b1;
          res_d.kind   = dtq_pkg::KIND_EXPIRY;
          res_d.status = dtq_pkg::ST_OK;
          res_d.owner  = pend_q;
          res_d.now    = time_q;
          res_d.last   = 1'b1;
          state_d      = dtq_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = dtq_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dtq_pkg::S_IDLE;
      time_q      <= '0;
      running_q   <= 1'b0;
      count_q     <= '0;
      head_q      <= '0;
      k_q         <= '0;
      n_q         <= '0;
      have_pend_q <= 1'b0;
      ov_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      time_q      <= time_d;
      running_q   <= running_d;
      count_q     <= count_d;
      head_q      <= head_d;
      k_q         <= k_d;
      n_q         <= n_d;
      have_pend_q <= have_pend_d;
      ov_q        <= ov_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    newe_q   <= newe_d;
    pend_q   <= pend_d;
    rep_st_q <= rep_st_d;
    res_q    <= res_d;
  end

  // result port
  assign out_o.valid         = ov_q;
  assign out_o.kind          = res_q.kind;
  assign out_o.status        = res_q.status;
  assign out_o.expired_owner = res_q.owner;
  assign out_o.now_time      = res_q.now;
  assign out_o.last          = res_q.last;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= dtq_pkg::CNT_W'(dtq_pkg::DEPTH))
    else $error("entry count above table depth");

  a_time_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    time_q >= $past(time_q))
    else $error("time count went backward");

  a_stop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.op == dtq_pkg::OP_STOP && running_q)
    |=> (count_q == '0 && !running_q))
    else $error("stop did not clear the table");

  a_status_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && res_q.kind == dtq_pkg::KIND_STATUS) |-> (res_q.owner == '0 && res_q.last))
    else $error("status reply with owner or without last");
`endif

endmodule

>>> rtl/dtq_table.sv
// deadline table: circular single-port-read memory addressed relative to the head
module dtq_table (
  input  logic              clk_i,
  input  dtq_pkg::tbl_req_t req_i,
  output dtq_pkg::entry_t   rdata_o
);

  localparam int unsigned SUM_W = dtq_pkg::CNT_W + 1;

  dtq_pkg::entry_t            mem_q [dtq_pkg::DEPTH];
  dtq_pkg::entry_t            rdata_q;
  logic [dtq_pkg::IDX_W-1:0]  rd_addr;
  logic [dtq_pkg::IDX_W-1:0]  wr_addr;
  logic [SUM_W-1:0]           rd_sum;
  logic [SUM_W-1:0]           wr_sum;

  // map offsets from the head onto physical slots, wrapping once
  always_comb begin
    rd_sum = SUM_W'(req_i.head) + SUM_W'(req_i.rd_off);
    wr_sum = SUM_W'(req_i.head) + SUM_W'(req_i.wr_off);
    if (rd_sum >= SUM_W'(dtq_pkg::DEPTH)) begin
      rd_sum = rd_sum - SUM_W'(dtq_pkg::DEPTH);
    end
    if (wr_sum >= SUM_W'(dtq_pkg::DEPTH)) begin
      wr_sum = wr_sum - SUM_W'(dtq_pkg::DEPTH);
    end
    rd_addr = rd_sum[dtq_pkg::IDX_W-1:0];
    wr_addr = wr_sum[dtq_pkg::IDX_W-1:0];
  end

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[wr_addr] <= req_i.wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
